FILE: design/hrrn_pkg.sv
// Shared types, codes and constants of the HRRN ready-queue scheduler.
package hrrn_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam logic [19:0] EST_MAX = 20'hFFFFF;

    localparam logic [1:0] OP_ENQUEUE  = 2'd0;
    localparam logic [1:0] OP_DISPATCH = 2'd1;
    localparam logic [1:0] OP_UPDATE   = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic MODE_FIFO = 1'b0;

    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_WEIGHT = 1'b1;

    localparam logic [8:0] WEIGHT_ONE = 9'd256;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] proc_id;
        logic [19:0] burst_estimate;
        logic [31:0] now_ms;
        logic [31:0] run_start_ms;
    } t_in_req;

    typedef struct packed {
        logic [15:0] chosen_id;
        logic [19:0] estimate_out;
        logic [1:0]  status;
    } t_out_rsp;

    typedef struct packed {
        logic [15:0] id;
        logic [19:0] est;
        logic [31:0] t;
    } t_entry;

    typedef struct packed {
        logic write;
        logic rotate;
        logic compact;
    } t_cell_ctl;

endpackage

FILE: design/hrrn_ready_queue_scheduler.sv
// Top level of the HRRN ready-queue scheduler: control, ratio compare and cell chain.
// Enqueue and unused opcodes go from idle straight to S_RESP; update passes S_UPD first.
// FIFO dispatch removes the head in S_REM. HRRN dispatch makes one full rotation of the ring,
// passing each live entry through a four-step ratio compare, then removes the best in S_REM.
// One request at a time; the next is taken once the result sits in the output register.
// Synchronous active-low reset empties the queue and sets HRRN mode and weight 128.
module hrrn_ready_queue_scheduler #(
    parameter int QUEUE_DEPTH = hrrn_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hrrn_pkg::t_in_req  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hrrn_pkg::t_out_rsp o_out_data,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [8:0]         i_cfg_data
);
    import hrrn_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NUM  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_REM  = 3'd5;
    localparam logic [2:0] S_UPD  = 3'd6;
    localparam logic [2:0] S_RESP = 3'd7;

    logic [2:0]    r_state;
    logic [CW-1:0] r_count;
    logic          r_mode;
    logic [8:0]    r_weight;
    t_in_req       r_req;
    t_out_rsp      r_rsp;
    t_out_rsp      r_out;
    logic          r_out_valid;
    logic [IW-1:0] r_k;
    logic [IW-1:0] r_best;
    logic [32:0]   r_num;
    logic [19:0]   r_e;
    logic [32:0]   r_best_num;
    logic [19:0]   r_best_e;
    logic [35:0]   r_pa_lo;
    logic [36:0]   r_pa_hi;
    logic [35:0]   r_pb_lo;
    logic [36:0]   r_pb_hi;
    logic [52:0]   r_a;
    logic [52:0]   r_b;
    logic [28:0]   r_p1;
    logic [40:0]   r_p2;

    t_cell_ctl     ctl;
    logic [IW-1:0] sel;
    t_entry        new_entry;
    t_entry        cells [QUEUE_DEPTH];
    t_entry        head;
    logic          in_acc;
    logic          last_k;
    logic          k_live;
    logic [19:0]   head_e;
    logic [31:0]   wait_t;
    logic [31:0]   run_t;
    logic [8:0]    w_eff;
    logic [41:0]   upd_sum;
    logic [33:0]   upd_val;

    assign in_acc = i_in_valid && !o_in_stall;
    assign head   = cells[0];
    assign last_k = (r_k == IW'(QUEUE_DEPTH - 1));
    assign k_live = (CW'(r_k) < r_count);
    assign head_e = (head.est == 20'd0) ? 20'd1 : head.est;
    assign wait_t = r_req.now_ms - head.t;
    assign run_t  = i_in_data.now_ms - i_in_data.run_start_ms;
    assign w_eff  = (r_weight > WEIGHT_ONE) ? WEIGHT_ONE : r_weight;
    assign upd_sum = 42'(r_p1) + 42'(r_p2);
    assign upd_val = upd_sum[41:8];

    assign new_entry.id  = i_in_data.proc_id;
    assign new_entry.est = i_in_data.burst_estimate;
    assign new_entry.t   = i_in_data.now_ms;

    always_comb begin
        ctl = '0;
        sel = r_best;
        case (r_state)
            S_IDLE: begin
                sel = r_count[IW-1:0];
                ctl.write = in_acc && (i_in_data.opcode == OP_ENQUEUE)
                            && (r_count != CW'(QUEUE_DEPTH));
            end
            S_NUM:   ctl.rotate = !k_live;
            S_CMP:   ctl.rotate = 1'b1;
            S_REM:   ctl.compact = 1'b1;
            default: ctl = '0;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            hrrn_cell #(
                .QUEUE_DEPTH(QUEUE_DEPTH),
                .CELL_IDX   (g)
            ) u_cell (
                .i_clk  (i_clk),
                .i_ctl  (ctl),
                .i_sel  (sel),
                .i_new  (new_entry),
                .i_next (cells[(g + 1) % QUEUE_DEPTH]),
                .o_entry(cells[g])
            );
        end
    endgenerate

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b1;
            r_weight <= 9'd128;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_MODE) begin
                r_mode <= i_cfg_data[0];
            end else if (i_cfg_idx == REG_WEIGHT) begin
                r_weight <= i_cfg_data;
            end
        end
    end

    // Control sequence and ratio compare datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_req <= i_in_data;
                        r_k   <= '0;
                        r_p1  <= 29'((WEIGHT_ONE - w_eff) * i_in_data.burst_estimate);
                        r_p2  <= 41'(w_eff * run_t);
                        case (i_in_data.opcode)
                            OP_ENQUEUE: begin
                                r_state <= S_RESP;
                                if (r_count == CW'(QUEUE_DEPTH)) begin
                                    r_rsp <= '{16'd0, 20'd0, ST_FULL};
                                end else begin
                                    r_rsp   <= '0;
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            OP_DISPATCH: begin
                                if (r_count == '0) begin
                                    r_rsp   <= '{16'd0, 20'd0, ST_EMPTY};
                                    r_state <= S_RESP;
                                end else if (r_mode == MODE_FIFO) begin
                                    r_best  <= '0;
                                    r_rsp   <= '{head.id, head.est, ST_OK};
                                    r_state <= S_REM;
                                end else begin
                                    r_rsp   <= '0;
                                    r_state <= S_NUM;
                                end
                            end
                            OP_UPDATE: begin
                                r_rsp   <= '0;
                                r_state <= S_UPD;
                            end
                            default: begin
                                r_rsp   <= '0;
                                r_state <= S_RESP;
                            end
                        endcase
                    end
                end
                S_NUM: begin
                    if (k_live) begin
                        r_num   <= 33'(head_e) + 33'(wait_t);
                        r_e     <= head_e;
                        r_state <= S_MUL;
                    end else if (last_k) begin
                        r_state <= S_REM;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_MUL: begin
                    r_pa_lo <= r_num[15:0] * r_best_e;
                    r_pa_hi <= r_num[32:16] * r_best_e;
                    r_pb_lo <= r_best_num[15:0] * r_e;
                    r_pb_hi <= r_best_num[32:16] * r_e;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_a <= {r_pa_hi, 16'd0} + 53'(r_pa_lo);
                    r_b <= {r_pb_hi, 16'd0} + 53'(r_pb_lo);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // Strictly greater only, so a tie keeps the earlier entry.
                    if ((r_k == '0) || (r_a > r_b)) begin
                        r_best     <= r_k;
                        r_best_e   <= r_e;
                        r_best_num <= r_num;
                        r_rsp.chosen_id    <= head.id;
                        r_rsp.estimate_out <= head.est;
                    end
                    if (last_k) begin
                        r_state <= S_REM;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_NUM;
                    end
                end
                S_REM: begin
                    r_count <= r_count - 1'b1;
                    r_state <= S_RESP;
                end
                S_UPD: begin
                    r_rsp.estimate_out <= (upd_val > 34'(EST_MAX)) ? EST_MAX : upd_val[19:0];
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_RESP) && (!r_out_valid || !i_out_stall)) begin
            r_out_valid <= 1'b1;
            r_out       <= r_rsp;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("request taken while previous one in flight");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.opcode == OP_ENQUEUE) && (r_count == CW'(QUEUE_DEPTH)))
        |=> (r_rsp.status == ST_FULL) && (r_count == CW'(QUEUE_DEPTH)))
        else $error("enqueue into full queue changed state");

endmodule

FILE: design/hrrn_cell.sv
// One queue slot of the scheduler chain.
module hrrn_cell #(
    parameter int QUEUE_DEPTH = 16,
    parameter int CELL_IDX    = 0
) (
    input  logic                           i_clk,
    input  hrrn_pkg::t_cell_ctl            i_ctl,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_sel,
    input  hrrn_pkg::t_entry               i_new,
    input  hrrn_pkg::t_entry               i_next,
    output hrrn_pkg::t_entry               o_entry
);
    import hrrn_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.write && (i_sel == IW'(CELL_IDX))) begin
            r_entry <= i_new;
        end else if (i_ctl.rotate) begin
            r_entry <= i_next;
        end else if (i_ctl.compact && (IW'(CELL_IDX) >= i_sel)) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

FILE: dv/hrrn_ready_queue_scheduler_checker.sv
// Checker for the HRRN ready-queue scheduler: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module hrrn_ready_queue_scheduler_checker
    import hrrn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_in_req  i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_out_rsp i_out_data,
    input  logic     i_cfg_we,
    input  logic     i_cfg_idx,
    input  logic [8:0] i_cfg_data,
    output int       o_fail_count,
    output int       o_pending
);

    localparam int DEPTH = QUEUE_DEPTH_DEF;

    logic        mode_q;
    logic [8:0]  weight_q;
    t_entry      ready_q [DEPTH];
    int          count_q;
    t_out_rsp    rsp_expected [$];

    assign o_pending = rsp_expected.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    function automatic int pick_best(input logic [31:0] now);
        int          best;
        logic [63:0] best_e, best_num, e, num;
        best = 0;
        best_e = 1;
        best_num = 1;
        for (int i = 0; i < count_q; i++) begin
            e = (ready_q[i].est == 0) ? 64'd1 : 64'(ready_q[i].est);
            num = e + 64'(32'(now - ready_q[i].t));
            if (i == 0 || num * best_e > best_num * e) begin
                best = i;
                best_e = e;
                best_num = num;
            end
        end
        return best;
    endfunction

    task automatic predict_response(input t_in_req req);
        t_out_rsp    rsp;
        int          idx;
        logic [63:0] w, v;
        rsp = '0;
        case (req.opcode)
            OP_ENQUEUE: begin
                if (count_q >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    ready_q[count_q] = '{req.proc_id, req.burst_estimate, req.now_ms};
                    count_q++;
                end
            end
            OP_DISPATCH: begin
                if (count_q == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    idx = (mode_q == MODE_FIFO) ? 0 : pick_best(req.now_ms);
                    rsp.chosen_id = ready_q[idx].id;
                    rsp.estimate_out = ready_q[idx].est;
                    for (int i = idx; i + 1 < count_q; i++) ready_q[i] = ready_q[i + 1];
                    count_q--;
                end
            end
            OP_UPDATE: begin
                w = (weight_q > WEIGHT_ONE) ? 64'd256 : 64'(weight_q);
                v = ((64'd256 - w) * 64'(req.burst_estimate)
                     + w * 64'(32'(req.now_ms - req.run_start_ms))) >> 8;
                rsp.estimate_out = (v > 64'(EST_MAX)) ? EST_MAX : v[19:0];
            end
            default: ;
        endcase
        rsp_expected.push_back(rsp);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_q <= 1'b1;
            weight_q <= 9'd128;
            count_q = 0;
            rsp_expected.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_MODE) mode_q <= i_cfg_data[0];
                else weight_q <= i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) predict_response(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (rsp_expected.size() == 0) begin
                    report_mismatch("unexpected response", 32'(i_out_data), 0);
                end else begin
                    t_out_rsp want;
                    want = rsp_expected.pop_front();
                    if (i_out_data.chosen_id !== want.chosen_id)
                        report_mismatch("chosen_id", i_out_data.chosen_id, want.chosen_id);
                    if (i_out_data.estimate_out !== want.estimate_out)
                        report_mismatch("estimate_out", i_out_data.estimate_out,
                                        want.estimate_out);
                    if (i_out_data.status !== want.status)
                        report_mismatch("status", i_out_data.status, want.status);
                end
            end
        end
    end

endmodule

FILE: dv/hrrn_ready_queue_scheduler_tb.sv
// Testbench top of the HRRN ready-queue scheduler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module hrrn_ready_queue_scheduler_tb;
    import hrrn_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_req    in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_rsp   out_data;
    logic       cfg_we = 1'b0;
    logic       cfg_idx = 1'b0;
    logic [8:0] cfg_data = '0;
    int         fail_count;
    int         pending;
    int         cycle_count = 0;
    int         hold_off = 0;
    logic [31:0] clock_ms = 0;

    always #5 clk = ~clk;

    hrrn_ready_queue_scheduler dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    hrrn_ready_queue_scheduler_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int gap_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    endfunction

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off requested by the stimulus.
    initial begin
        int n;
        forever begin
            @(posedge clk);
            if (hold_off > 0) begin
                out_stall <= 1'b1;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                n = gap_length();
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [8:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic send_request(input t_in_req req);
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if ($urandom_range(0, 2) == 0) begin
            in_valid <= 1'b0;
            repeat (gap_length()) @(posedge clk);
        end
    endtask

    task automatic send_fields(input logic [1:0] op, input logic [15:0] id,
                               input logic [19:0] est, input logic [31:0] now,
                               input logic [31:0] start);
        t_in_req req;
        req = '{op, id, est, now, start};
        send_request(req);
    endtask

    task automatic random_request(input int fill_bias);
        logic [1:0]  op;
        logic [19:0] est;
        clock_ms = clock_ms + $urandom_range(0, 3000);
        if ($urandom_range(0, 19) == 0) op = OP_UNUSED;
        else if ($urandom_range(0, 99) < fill_bias) op = OP_ENQUEUE;
        else op = ($urandom_range(0, 3) == 0) ? OP_UPDATE : OP_DISPATCH;
        case ($urandom_range(0, 5))
            0: est = 20'd0;
            1: est = EST_MAX;
            2: est = 20'($urandom);
            default: est = 20'($urandom_range(1, 500));
        endcase
        send_fields(op, 16'($urandom), est,
                    ($urandom_range(0, 9) == 0) ? $urandom : clock_ms,
                    ($urandom_range(0, 4) == 0) ? $urandom : clock_ms - $urandom_range(0, 5000));
    endtask

    initial begin
        logic [8:0] weights [4] = '{9'd0, 9'd256, 9'd511, 9'd77};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty dispatch, zero estimate, ties, wrap of wait time, full queue.
        send_fields(OP_DISPATCH, 16'h0, 20'h0, 32'h0, 32'h0);
        send_fields(OP_ENQUEUE, 16'hFFFF, 20'd0, 32'hFFFF_FFF0, 32'h0);
        send_fields(OP_ENQUEUE, 16'h0001, EST_MAX, 32'h0, 32'hFFFF_FFFF);
        send_fields(OP_ENQUEUE, 16'h0002, 20'd10, 32'd100, 32'h0);
        send_fields(OP_ENQUEUE, 16'h0003, 20'd10, 32'd100, 32'h0);
        send_fields(OP_DISPATCH, 16'h0, 20'h0, 32'd200, 32'h0);
        send_fields(OP_DISPATCH, 16'h0, 20'h0, 32'd200, 32'h0);
        send_fields(OP_UPDATE, 16'h0, EST_MAX, 32'hFFFF_FFFF, 32'h0);
        send_fields(OP_UPDATE, 16'hFFFF, 20'd0, 32'h0, 32'hFFFF_FFFF);
        send_fields(OP_UNUSED, 16'hFFFF, EST_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 16; i++)
            send_fields(OP_ENQUEUE, 16'(i + 16), 20'(i * 7), 32'(i * 3), 32'h0);
        wait_idle();

        // Long receiver hold-off while the queue is filled and overflowed.
        hold_off = 400;
        for (int i = 0; i < 20; i++) random_request(100);
        wait_idle();

        for (int phase = 0; phase < 8; phase++) begin
            write_reg(REG_MODE, 9'(phase & 1));
            write_reg(REG_WEIGHT, weights[phase % 4]);
            for (int i = 0; i < 110; i++) random_request((i % 40) < 20 ? 75 : 35);
            in_valid <= 1'b0;
            wait_idle();
        end

        in_valid <= 1'b0;
        wait_idle();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
